@@ src/sbot_pkg.sv @@
// ----------------------------------------------------------------------------
// sbot_pkg
// Shared types and constants for the segment versus box overlap test:
// field widths, configuration register indexes and the segment setup struct.
// ----------------------------------------------------------------------------
package sbot_pkg;

  localparam int CoordW   = 32;
  localparam int HalfLenW = 31;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  typedef enum logic [2:0] {
    RegMidX    = 3'd0,
    RegMidY    = 3'd1,
    RegMidZ    = 3'd2,
    RegDirX    = 3'd3,
    RegDirY    = 3'd4,
    RegDirZ    = 3'd5,
    RegHalfLen = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0]   mid_x;
    logic signed [CoordW-1:0]   mid_y;
    logic signed [CoordW-1:0]   mid_z;
    logic signed [CoordW-1:0]   dir_x;
    logic signed [CoordW-1:0]   dir_y;
    logic signed [CoordW-1:0]   dir_z;
    logic        [HalfLenW-1:0] half_len;
  } seg_cfg_t;

endpackage

@@ src/sbot_regs.sv @@
// ----------------------------------------------------------------------------
// sbot_regs
// APB-style register file holding the segment midpoint, direction and half
// length. Writes complete in the access phase, reads return the stored value.
// ----------------------------------------------------------------------------
module sbot_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sbot_pkg::AddrW-1:0] paddr,
  input  logic [sbot_pkg::DataW-1:0] pwdata,
  output logic [sbot_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output sbot_pkg::seg_cfg_t         cfg_o
);
  import sbot_pkg::*;

  seg_cfg_t cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegMidX:    cfg_q.mid_x    <= pwdata;
        RegMidY:    cfg_q.mid_y    <= pwdata;
        RegMidZ:    cfg_q.mid_z    <= pwdata;
        RegDirX:    cfg_q.dir_x    <= pwdata;
        RegDirY:    cfg_q.dir_y    <= pwdata;
        RegDirZ:    cfg_q.dir_z    <= pwdata;
        RegHalfLen: cfg_q.half_len <= pwdata[HalfLenW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMidX:    prdata = cfg_q.mid_x;
      RegMidY:    prdata = cfg_q.mid_y;
      RegMidZ:    prdata = cfg_q.mid_z;
      RegDirX:    prdata = cfg_q.dir_x;
      RegDirY:    prdata = cfg_q.dir_y;
      RegDirZ:    prdata = cfg_q.dir_z;
      RegHalfLen: prdata = {{(DataW-HalfLenW){1'b0}}, cfg_q.half_len};
      default:    prdata = '0;
    endcase
  end

endmodule

@@ src/segment_box_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// segment_box_overlap_test_core
// Separating-axis overlap test of a configured line segment against a stream
// of axis-aligned boxes, exact fixed-point arithmetic, one hit flag per box.
//
//   channel   direction  handshake                  payload
//   box       in         box_valid_i / box_stall_o  box_max_{x,y,z}_i, box_min_{x,y,z}_i
//   hit       out        hit_valid_o / hit_stall_i  hit_o
//   config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One box per cycle unless hit_stall_i holds the pipeline back.
// Stages: extents and offsets, products, wide sums and face compares,
// cross compares into the output register.
// Each stage loads when empty or when the stage after it moves, so bubbles
// collapse and a stalled output holds the other stages only as they fill.
// Reset clears the stage valid bits, the hit flag and the segment registers;
// stage data is not reset.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               box_valid_i,
  output logic                               box_stall_o,
  input  logic signed [sbot_pkg::CoordW-1:0] box_max_x_i,
  input  logic signed [sbot_pkg::CoordW-1:0] box_max_y_i,
  input  logic signed [sbot_pkg::CoordW-1:0] box_max_z_i,
  input  logic signed [sbot_pkg::CoordW-1:0] box_min_x_i,
  input  logic signed [sbot_pkg::CoordW-1:0] box_min_y_i,
  input  logic signed [sbot_pkg::CoordW-1:0] box_min_z_i,
  output logic                               hit_valid_o,
  input  logic                               hit_stall_i,
  output logic                               hit_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sbot_pkg::AddrW-1:0]         paddr,
  input  logic [sbot_pkg::DataW-1:0]         pwdata,
  output logic [sbot_pkg::DataW-1:0]         prdata,
  output logic                               pready
);
  import sbot_pkg::*;

  localparam int ExtW  = CoordW + 1;
  localparam int OffW  = CoordW + 2;
  localparam int HdW   = HalfLenW + CoordW + 1;
  localparam int FlhsW = OffW + 16;
  localparam int FaceW = HdW + 2;
  localparam int ProdW = OffW + CoordW;
  localparam int SumW  = ProdW + 1;
  localparam int AxA [3] = '{1, 2, 0};
  localparam int AxB [3] = '{2, 0, 1};

  seg_cfg_t cfg;

  sbot_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // segment setup as per-axis arrays
  logic signed [CoordW-1:0] mid [3];
  logic signed [CoordW-1:0] dir [3];
  logic        [CoordW-1:0] dmag [3];
  logic signed [CoordW-1:0] bmax [3];
  logic signed [CoordW-1:0] bmin [3];

  always_comb begin
    mid[0]  = cfg.mid_x;
    mid[1]  = cfg.mid_y;
    mid[2]  = cfg.mid_z;
    dir[0]  = cfg.dir_x;
    dir[1]  = cfg.dir_y;
    dir[2]  = cfg.dir_z;
    bmax[0] = box_max_x_i;
    bmax[1] = box_max_y_i;
    bmax[2] = box_max_z_i;
    bmin[0] = box_min_x_i;
    bmin[1] = box_min_y_i;
    bmin[2] = box_min_z_i;
    for (int k = 0; k < 3; k++) begin
      dmag[k] = dir[k][CoordW-1] ? (~dir[k] + CoordW'(1)) : dir[k];
    end
  end

  // stage flow control
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_q || !hit_stall_i;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign box_stall_o = !rdy1;
  assign hit_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= box_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: doubled half extents, doubled center offsets, 2*h*|d|
  logic signed [ExtW-1:0] e1_d  [3];
  logic signed [OffW-1:0] t1_d  [3];
  logic        [HdW-1:0]  hd1_d [3];
  logic signed [ExtW-1:0] e1_q  [3];
  logic signed [OffW-1:0] t1_q  [3];
  logic        [HdW-1:0]  hd1_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_d[k]  = ExtW'(bmax[k]) - ExtW'(bmin[k]);
      t1_d[k]  = OffW'(bmax[k]) + OffW'(bmin[k]) - (OffW'(mid[k]) <<< 1);
      hd1_d[k] = {(HdW-1)'((HdW-1)'(cfg.half_len) * (HdW-1)'(dmag[k])), 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && box_valid_i) begin
      e1_q  <= e1_d;
      t1_q  <= t1_d;
      hd1_q <= hd1_d;
    end
  end

  // stage 2: face sides and cross-axis products
  logic        [FlhsW-1:0] flhs2_d [3];
  logic signed [FaceW-1:0] frhs2_d [3];
  logic signed [ProdW-1:0] pa2_d   [3];
  logic signed [ProdW-1:0] pb2_d   [3];
  logic signed [ProdW-1:0] qa2_d   [3];
  logic signed [ProdW-1:0] qb2_d   [3];
  logic        [FlhsW-1:0] flhs2_q [3];
  logic signed [FaceW-1:0] frhs2_q [3];
  logic signed [ProdW-1:0] pa2_q   [3];
  logic signed [ProdW-1:0] pb2_q   [3];
  logic signed [ProdW-1:0] qa2_q   [3];
  logic signed [ProdW-1:0] qb2_q   [3];

  always_comb begin
    logic [OffW-1:0] tmag;
    for (int k = 0; k < 3; k++) begin
      tmag        = t1_q[k][OffW-1] ? (~t1_q[k] + OffW'(1)) : t1_q[k];
      flhs2_d[k]  = {tmag, 16'b0};
      frhs2_d[k]  = (FaceW'(e1_q[k]) <<< 16) + $signed({2'b0, hd1_q[k]});
      pa2_d[k]    = ProdW'(t1_q[AxA[k]]) * ProdW'(dir[AxB[k]]);
      pb2_d[k]    = ProdW'(t1_q[AxB[k]]) * ProdW'(dir[AxA[k]]);
      qa2_d[k]    = ProdW'(e1_q[AxA[k]]) * $signed(ProdW'({1'b0, dmag[AxB[k]]}));
      qb2_d[k]    = ProdW'(e1_q[AxB[k]]) * $signed(ProdW'({1'b0, dmag[AxA[k]]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      flhs2_q <= flhs2_d;
      frhs2_q <= frhs2_d;
      pa2_q   <= pa2_d;
      pb2_q   <= pb2_d;
      qa2_q   <= qa2_d;
      qb2_q   <= qb2_d;
    end
  end

  // stage 3: face compares, cross differences and bounds
  logic        [2:0]      fsep3_d;
  logic signed [SumW-1:0] cd3_d [3];
  logic signed [SumW-1:0] cr3_d [3];
  logic        [2:0]      fsep3_q;
  logic signed [SumW-1:0] cd3_q [3];
  logic signed [SumW-1:0] cr3_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fsep3_d[k] = $signed(FaceW'(flhs2_q[k])) > frhs2_q[k];
      cd3_d[k]   = SumW'(pa2_q[k]) - SumW'(pb2_q[k]);
      cr3_d[k]   = SumW'(qa2_q[k]) + SumW'(qb2_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      fsep3_q <= fsep3_d;
      cd3_q   <= cd3_d;
      cr3_q   <= cr3_d;
    end
  end

  // stage 4: cross compares and hit flag
  logic [2:0] csep4;
  logic       hit_d;
  logic       hit_q;

  always_comb begin
    logic [SumW-1:0] cmag;
    for (int k = 0; k < 3; k++) begin
      cmag     = cd3_q[k][SumW-1] ? (~cd3_q[k] + SumW'(1)) : cd3_q[k];
      csep4[k] = $signed({1'b0, cmag}) > (SumW + 1)'(cr3_q[k]);
    end
    hit_d = ~(|fsep3_q | |csep4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rdy4 && v3_q) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

@@ tb/sv/segment_box_overlap_test_core_tb.sv @@
// ----------------------------------------------------------------------------
// segment_box_overlap_test_core_tb
// Self-checking bench for the segment versus box overlap test. It loads
// segments over the register port, streams boxes with random gaps and
// output stalls, works out each hit flag with an exact wide-integer
// separating-axis check and compares it with the block's answer in order.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbot_pkg::*;

  localparam int Latency = 4;
  localparam int Phases = 12;
  localparam int PhaseBoxes = 125;
  localparam logic [AddrW-1:0] UnusedAddr = 5'd28;

  localparam logic [31:0] MaxC     = 32'h7FFF_FFFF;
  localparam logic [31:0] MinC     = 32'h8000_0000;
  localparam logic [31:0] OneQ     = 32'h0001_0000;
  localparam logic [31:0] TwoQ     = 32'h0002_0000;
  localparam logic [31:0] ThreeQ   = 32'h0003_0000;
  localparam logic [31:0] FourQ    = 32'h0004_0000;
  localparam logic [31:0] HalfQ    = 32'h0000_8000;
  localparam logic [31:0] NegHalf  = 32'hFFFF_8000;
  localparam logic [31:0] NegOne   = 32'hFFFF_0000;
  localparam logic [31:0] NegTwo   = 32'hFFFE_0000;
  localparam logic [31:0] NearOne  = 32'h0000_E666;
  localparam logic [31:0] NegNear  = 32'hFFFF_199A;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
  } box_t;

  typedef enum int {SegExtreme, SegFull, SegModest} seg_mix_e;

  class segment_hit_board;
    seg_cfg_t seg;
    bit expected_hits[$];
    int unsigned errors;

    function new();
      seg = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        RegMidX:    seg.mid_x = value;
        RegMidY:    seg.mid_y = value;
        RegMidZ:    seg.mid_z = value;
        RegDirX:    seg.dir_x = value;
        RegDirY:    seg.dir_y = value;
        RegDirZ:    seg.dir_z = value;
        RegHalfLen: seg.half_len = value[HalfLenW-1:0];
        default: ;
      endcase
    endfunction

    function wide_t mag(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    function bit face_apart(wide_t t, wide_t e, wide_t d, wide_t h);
      return mag(t) * 65536 > e * 65536 + 2 * h * mag(d);
    endfunction

    function bit cross_apart(wide_t ta, wide_t tb, wide_t da, wide_t db,
                             wide_t ea, wide_t eb);
      return mag(ta * db - tb * da) > ea * mag(db) + eb * mag(da);
    endfunction

    // doubled extents and doubled center offsets keep everything exact
    function bit predict_hit(box_t b);
      wide_t ex, ey, ez, tx, ty, tz, dx, dy, dz, h;
      ex = wide_t'(b.max_x) - wide_t'(b.min_x);
      ey = wide_t'(b.max_y) - wide_t'(b.min_y);
      ez = wide_t'(b.max_z) - wide_t'(b.min_z);
      tx = wide_t'(b.max_x) + wide_t'(b.min_x) - 2 * wide_t'($signed(seg.mid_x));
      ty = wide_t'(b.max_y) + wide_t'(b.min_y) - 2 * wide_t'($signed(seg.mid_y));
      tz = wide_t'(b.max_z) + wide_t'(b.min_z) - 2 * wide_t'($signed(seg.mid_z));
      dx = wide_t'($signed(seg.dir_x));
      dy = wide_t'($signed(seg.dir_y));
      dz = wide_t'($signed(seg.dir_z));
      h = wide_t'(seg.half_len);
      return !(face_apart(tx, ex, dx, h) || face_apart(ty, ey, dy, h) ||
               face_apart(tz, ez, dz, h) ||
               cross_apart(ty, tz, dy, dz, ey, ez) ||
               cross_apart(tz, tx, dz, dx, ez, ex) ||
               cross_apart(tx, ty, dx, dy, ex, ey));
    endfunction

    function void note_box(box_t b);
      expected_hits.push_back(predict_hit(b));
    endfunction

    function void check_hit(logic actual);
      bit want;
      if (expected_hits.size() == 0) begin
        $display("%0t: hit result %0b with none expected", $time, actual);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (actual !== want) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       box_valid_i = 1'b0;
  logic                       box_stall_o;
  logic signed [CoordW-1:0]   box_max_x_i = '0;
  logic signed [CoordW-1:0]   box_max_y_i = '0;
  logic signed [CoordW-1:0]   box_max_z_i = '0;
  logic signed [CoordW-1:0]   box_min_x_i = '0;
  logic signed [CoordW-1:0]   box_min_y_i = '0;
  logic signed [CoordW-1:0]   box_min_z_i = '0;
  logic                       hit_valid_o;
  logic                       hit_stall_i = 1'b0;
  logic                       hit_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [AddrW-1:0]           paddr = '0;
  logic [DataW-1:0]           pwdata = '0;
  logic [DataW-1:0]           prdata;
  logic                       pready;

  segment_hit_board sb = new();
  bit send_burst = 1'b0;
  bit drain_burst = 1'b0;

  segment_box_overlap_test_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_valid_i (box_valid_i),
    .box_stall_o (box_stall_o),
    .box_max_x_i (box_max_x_i),
    .box_max_y_i (box_max_y_i),
    .box_max_z_i (box_max_z_i),
    .box_min_x_i (box_min_x_i),
    .box_min_y_i (box_min_y_i),
    .box_min_z_i (box_min_z_i),
    .hit_valid_o (hit_valid_o),
    .hit_stall_i (hit_stall_i),
    .hit_o       (hit_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 500_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hit_valid_o && !hit_stall_i) begin
        sb.check_hit(hit_o);
      end
      if (box_valid_i && !box_stall_o) begin
        sb.note_box({box_max_x_i, box_max_y_i, box_max_z_i,
                     box_min_x_i, box_min_y_i, box_min_z_i});
      end
    end
  end

  // output stalls, with stretches of none
  initial begin
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        drain_burst = !drain_burst;
      end
      hold = drain_burst ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        hit_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        hit_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!hit_valid_o);
    end
  end

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr[AddrW-1:2], data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_segment(input logic [31:0] mx, my, mz, dx, dy, dz, h);
    apb_write({RegMidX, 2'b00}, mx);
    apb_write({RegMidY, 2'b00}, my);
    apb_write({RegMidZ, 2'b00}, mz);
    apb_write({RegDirX, 2'b00}, dx);
    apb_write({RegDirY, 2'b00}, dy);
    apb_write({RegDirZ, 2'b00}, dz);
    apb_write({RegHalfLen, 2'b00}, h);
  endtask

  task automatic send_box(input box_t b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) begin
      send_burst = !send_burst;
    end
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      box_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    box_valid_i <= 1'b1;
    box_max_x_i <= b.max_x;
    box_max_y_i <= b.max_y;
    box_max_z_i <= b.max_z;
    box_min_x_i <= b.min_x;
    box_min_y_i <= b.min_y;
    box_min_z_i <= b.min_z;
    do @(posedge clk_i); while (box_stall_o);
  endtask

  task automatic settle();
    box_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic box_t mk_box(input logic [31:0] x1, y1, z1, x0, y0, z0);
    return {x1, y1, z1, x0, y0, z0};
  endfunction

  function automatic logic [31:0] pick_coord(seg_mix_e mix, int span);
    case (mix)
      SegExtreme: begin
        case ($urandom_range(0, 3))
          0: return MinC;
          1: return MaxC;
          2: return '0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      SegFull: return $urandom;
      default: return 32'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic [31:0] pick_dir(seg_mix_e mix);
    if (mix == SegModest && $urandom_range(0, 7) == 0) begin
      return '0;
    end
    return pick_coord(mix, 1 << 18);
  endfunction

  task automatic load_segment(input seg_mix_e mix);
    logic [31:0] h;
    case (mix)
      SegExtreme: begin
        case ($urandom_range(0, 3))
          0: h = '0;
          1: h = 32'h0000_0001;
          2: h = MaxC;
          default: h = 32'hFFFF_FFFF;
        endcase
      end
      SegFull: h = $urandom;
      default: h = $urandom_range(0, 1 << 20);
    endcase
    set_segment(pick_coord(mix, 1 << 22), pick_coord(mix, 1 << 22),
                pick_coord(mix, 1 << 22), pick_dir(mix), pick_dir(mix),
                pick_dir(mix), h);
    apb_write(UnusedAddr, $urandom);
  endtask

  // box placed around a point on or just past the segment
  function automatic box_t near_box();
    wide_t m[3];
    wide_t d[3];
    wide_t h, c, e;
    int f, s;
    logic signed [CoordW-1:0] hi_c[3];
    logic signed [CoordW-1:0] lo_c[3];
    logic signed [CoordW-1:0] tmp;
    m[0] = wide_t'($signed(sb.seg.mid_x));
    m[1] = wide_t'($signed(sb.seg.mid_y));
    m[2] = wide_t'($signed(sb.seg.mid_z));
    d[0] = wide_t'($signed(sb.seg.dir_x));
    d[1] = wide_t'($signed(sb.seg.dir_y));
    d[2] = wide_t'($signed(sb.seg.dir_z));
    h = wide_t'(sb.seg.half_len);
    f = int'($urandom_range(0, 640)) - 320;
    s = $urandom_range(2, 22);
    for (int a = 0; a < 3; a++) begin
      c = m[a] + ((d[a] * h * f) >>> 24) + (int'($urandom_range(0, 2 << s)) - (1 << s));
      e = wide_t'($urandom_range(0, 1 << s));
      hi_c[a] = CoordW'(c + e);
      lo_c[a] = CoordW'(c - e);
      if ($urandom_range(0, 15) == 0) begin
        tmp = hi_c[a];
        hi_c[a] = lo_c[a];
        lo_c[a] = tmp;
      end
    end
    return {hi_c[0], hi_c[1], hi_c[2], lo_c[0], lo_c[1], lo_c[2]};
  endfunction

  initial begin
    seg_mix_e mix;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset segment is a point at the origin
    send_box(mk_box('0, '0, '0, '0, '0, '0));
    send_box(mk_box(MaxC, MaxC, MaxC, MinC, MinC, MinC));
    send_box(mk_box(MinC, MinC, MinC, MaxC, MaxC, MaxC));
    send_box(mk_box(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC));
    send_box(mk_box(MinC, MinC, MinC, MinC, MinC, MinC));
    settle();

    // unit segment along x, touching and just clear of faces
    set_segment('0, '0, '0, OneQ, '0, '0, OneQ);
    send_box(mk_box(TwoQ, OneQ, OneQ, OneQ, NegOne, NegOne));
    send_box(mk_box(TwoQ, OneQ, OneQ, OneQ + 1, NegOne, NegOne));
    send_box(mk_box(NegOne, OneQ, OneQ, NegTwo, NegOne, NegOne));
    send_box(mk_box(HalfQ, OneQ, OneQ, NegHalf, '0, NegOne));
    send_box(mk_box(HalfQ, OneQ, OneQ, NegHalf, 32'h1, NegOne));
    settle();

    // diagonal segment, cross axis separates or just touches a corner
    set_segment('0, '0, '0, OneQ, OneQ, '0, OneQ);
    send_box(mk_box(TwoQ, NegNear, OneQ, NearOne, NegTwo, NegOne));
    send_box(mk_box(OneQ, '0, OneQ, '0, NegOne, NegOne));
    settle();

    // zero direction acts as a point at the midpoint
    set_segment(OneQ, TwoQ, ThreeQ, '0, '0, '0, MaxC);
    apb_write(UnusedAddr, 32'hFFFF_FFFF);
    send_box(mk_box(TwoQ, ThreeQ, FourQ, '0, OneQ, TwoQ));
    send_box(mk_box(FourQ, ThreeQ, FourQ, TwoQ + 1, OneQ, TwoQ));
    settle();

    // extreme segment, half length upper bit ignored
    set_segment(MinC, MinC, MinC, MinC, MinC, MinC, 32'hFFFF_FFFF);
    send_box(mk_box(MaxC, MaxC, MaxC, MinC, MinC, MinC));
    send_box(mk_box(MinC, MinC, MinC, MaxC, MaxC, MaxC));
    send_box(mk_box(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC));
    send_box(mk_box(MinC, MinC, MinC, MinC, MinC, MinC));
    send_box(mk_box(MaxC, MinC, MaxC, MinC, MaxC, MinC));
    settle();

    for (int p = 0; p < Phases; p++) begin
      if (p == 0) begin
        mix = SegExtreme;
      end else if (p == 1) begin
        mix = SegFull;
      end else begin
        case ($urandom_range(0, 5))
          0: mix = SegExtreme;
          1: mix = SegFull;
          default: mix = SegModest;
        endcase
      end
      load_segment(mix);
      for (int i = 0; i < PhaseBoxes; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          send_box(near_box());
        end else begin
          send_box({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
